// ===== rtl/pfe_pkg.sv =====
//------------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants for the postfix expression evaluator.
//------------------------------------------------------------------------------
package pfe_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] CMD_NUM   = 2'd0;
	localparam logic [1:0] CMD_IDENT = 2'd1;
	localparam logic [1:0] CMD_OPER  = 2'd2;
	localparam logic [1:0] CMD_END   = 2'd3;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_MOD = 4'd4;
	localparam logic [3:0] OP_LT  = 4'd5;
	localparam logic [3:0] OP_GT  = 4'd6;
	localparam logic [3:0] OP_GE  = 4'd7;
	localparam logic [3:0] OP_LE  = 4'd8;
	localparam logic [3:0] OP_EQ  = 4'd9;
	localparam logic [3:0] OP_NE  = 4'd10;
	localparam logic [3:0] OP_AND = 4'd11;
	localparam logic [3:0] OP_OR  = 4'd12;
	localparam logic [3:0] OP_ASG = 4'd13;
	localparam logic [3:0] OP_NEG = 4'd14;
	localparam logic [3:0] OP_NOT = 4'd15;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_UNDER   = 3'd1;
	localparam logic [2:0] ERR_DIVZERO = 3'd2;
	localparam logic [2:0] ERR_ASSIGN  = 3'd3;
	localparam logic [2:0] ERR_OVER    = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic       load;    // capture token
		logic       rd_top;  // issue stack reads of top two
		logic       cap_ab;  // latch operands
		logic       exec;    // ALU op / push writeback
		logic       div_go;  // start divider
		logic       div_wb;  // write divider result
		logic       fin;     // end token: clear state
	} pfe_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_busy;
		logic is_div;
	} pfe_sts_t;

endpackage

// ===== rtl/pfe_if.sv =====
//------------------------------------------------------------------------------
// pfe_tok_if / pfe_res_if
// Valid/ready channels for tokens and results.
//------------------------------------------------------------------------------
interface pfe_tok_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [3:0]  op_code;
	logic signed [31:0] number_value;
	modport source (output valid, cmd, op_code, number_value, input ready);
	modport sink   (input valid, cmd, op_code, number_value, output ready);
endinterface

interface pfe_res_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] result_value;
	logic [2:0]  error_code;
	modport source (output valid, result_value, error_code, input ready);
	modport sink   (input valid, result_value, error_code, output ready);
endinterface

// ===== rtl/postfix_expression_evaluator.sv =====
// Postfix evaluator: each token passes through load, stack read, operand
// capture and execute; end tokens end in a finish step and emit one result
// word; div and mod run the one-bit-per-cycle divider before writeback.
// The stack is a 16-entry memory read through a registered port; no token
// is accepted while an earlier result word is still pending.
//------------------------------------------------------------------------------
// postfix_expression_evaluator
// RPN evaluator on a 32-bit operand stack with sticky error reporting.
//------------------------------------------------------------------------------
module postfix_expression_evaluator import pfe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	pfe_tok_if.sink   tok,
	pfe_res_if.source res
);
	pfe_cmd_t ctl;
	pfe_sts_t sts;

	pfe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(tok.valid), .in_ready(tok.ready), .in_cmd(tok.cmd),
		.out_valid(res.valid), .out_ready(res.ready),
		.sts(sts), .ctl(ctl)
	);

	pfe_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.cmd(tok.cmd), .op_code(tok.op_code), .number_value(tok.number_value),
		.sts(sts), .res_value(res.result_value), .res_error(res.error_code)
	);

`ifndef SYNTH
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.exec, ctl.div_go, ctl.div_wb, ctl.fin}))
		else $error("conflicting datapath commands");
	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |=> res.valid)
		else $error("end token produced no result");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> !tok.ready)
		else $error("token accepted during divide");
`endif
endmodule

// ===== rtl/pfe_div.sv =====
//------------------------------------------------------------------------------
// pfe_div
// Radix-2 restoring signed divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
module pfe_div import pfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        busy,
	output logic [31:0] quo,
	output logic [31:0] rem
);
	logic [31:0] q_q, r_q, d_q;
	logic [5:0]  cnt_q;
	logic        qneg_q, rneg_q;
	logic [32:0] trial;

	assign trial = {r_q, q_q[31]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= a[31] ? (32'd0 - a) : a;
			d_q    <= b[31] ? (32'd0 - b) : b;
			r_q    <= '0;
			qneg_q <= a[31] ^ b[31];
			rneg_q <= a[31];
		end else if (cnt_q != '0) begin
			if (!trial[32]) begin
				r_q <= trial[31:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= {r_q[30:0], q_q[31]};
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = qneg_q ? (32'd0 - q_q) : q_q;
	assign rem  = rneg_q ? (32'd0 - r_q) : r_q;
endmodule

// ===== rtl/pfe_datapath.sv =====
//------------------------------------------------------------------------------
// pfe_datapath
// Operand stack memory, count, error latch, ALU, divider and result register.
//------------------------------------------------------------------------------
module pfe_datapath import pfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pfe_cmd_t    ctl,
	input  logic [1:0]  cmd,
	input  logic [3:0]  op_code,
	input  logic [31:0] number_value,
	output pfe_sts_t    sts,
	output logic [31:0] res_value,
	output logic [2:0]  res_error
);
	logic [31:0] mem [STACK_DEPTH];
	logic [31:0] rd0_q, rd1_q, a_q, b_q;
	logic [1:0]  cmd_q;
	logic [3:0]  op_q;
	logic [31:0] num_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]  err_q;
	logic [PTR_W-1:0] top_idx, sec_idx, wr_idx;
	logic        wr_en;
	logic [31:0] wr_data, alu;
	logic        div_busy;
	logic [31:0] quo, rem;
	logic        is_unary, is_push;
	logic signed [31:0] sa, sb;

	assign top_idx  = PTR_W'(cnt_q - CNT_W'(1));
	assign sec_idx  = PTR_W'(cnt_q - CNT_W'(2));
	assign is_unary = (op_q == OP_NEG) || (op_q == OP_NOT);
	assign is_push  = (cmd_q == CMD_NUM) || (cmd_q == CMD_IDENT);
	assign sa = a_q;
	assign sb = b_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			op_q  <= op_code;
			num_q <= number_value;
		end
		if (ctl.rd_top) begin
			rd0_q <= mem[top_idx];
			rd1_q <= mem[sec_idx];
		end
		if (ctl.cap_ab) begin
			b_q <= rd0_q;
			a_q <= rd1_q;
		end
		if (wr_en) mem[wr_idx] <= wr_data;
	end

	always_comb begin
		unique case (op_q)
			OP_ADD:  alu = a_q + b_q;
			OP_SUB:  alu = a_q - b_q;
			OP_LT:   alu = {31'd0, sa < sb};
			OP_GT:   alu = {31'd0, sa > sb};
			OP_GE:   alu = {31'd0, sa >= sb};
			OP_LE:   alu = {31'd0, sa <= sb};
			OP_EQ:   alu = {31'd0, a_q == b_q};
			OP_NE:   alu = {31'd0, a_q != b_q};
			OP_AND:  alu = {31'd0, (a_q != '0) && (b_q != '0)};
			OP_OR:   alu = {31'd0, (a_q != '0) || (b_q != '0)};
			OP_NEG:  alu = 32'd0 - b_q;
			OP_NOT:  alu = {31'd0, b_q == '0};
			default: alu = a_q * b_q;  // mul; div/mod go through the divider
		endcase
	end

	// writeback decision: no write after error, see count checks
	logic        ok_exec;
	logic [CNT_W-1:0] cnt_nx;
	logic [2:0]  err_nx;
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = top_idx;
		wr_data = alu;
		cnt_nx  = cnt_q;
		err_nx  = err_q;
		ok_exec = (err_q == ERR_NONE);
		if (ctl.exec && ok_exec) begin
			if (is_push) begin
				if (cnt_q == CNT_W'(STACK_DEPTH)) begin
					err_nx = ERR_OVER;
				end else begin
					wr_en   = 1'b1;
					wr_idx  = PTR_W'(cnt_q);
					wr_data = (cmd_q == CMD_NUM) ? num_q : 32'd0;
					cnt_nx  = cnt_q + CNT_W'(1);
				end
			end else if (is_unary) begin
				if (cnt_q == '0) err_nx = ERR_UNDER;
				else wr_en = 1'b1;
			end else if (cnt_q < CNT_W'(2)) begin
				err_nx = ERR_UNDER;
			end else if (op_q == OP_ASG) begin
				err_nx = ERR_ASSIGN;
			end else if (op_q == OP_DIV || op_q == OP_MOD) begin
				if (b_q == '0) err_nx = ERR_DIVZERO;
			end else begin
				wr_en  = 1'b1;
				wr_idx = sec_idx;
				cnt_nx = cnt_q - CNT_W'(1);
			end
		end
		if (ctl.div_wb) begin
			wr_en   = 1'b1;
			wr_idx  = sec_idx;
			wr_data = (op_q == OP_DIV) ? quo : rem;
			cnt_nx  = cnt_q - CNT_W'(1);
		end
		if (ctl.fin) begin
			cnt_nx = '0;
			err_nx = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= ERR_NONE;
		end else begin
			cnt_q <= cnt_nx;
			err_q <= err_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			if (err_q != ERR_NONE) begin
				res_value <= '0;
				res_error <= err_q;
			end else if (cnt_q == '0) begin
				res_value <= '0;
				res_error <= ERR_UNDER;
			end else begin
				res_value <= rd0_q;
				res_error <= ERR_NONE;
			end
		end
	end

	pfe_div u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_go),
		.a(a_q), .b(b_q), .busy(div_busy), .quo(quo), .rem(rem)
	);

	// divider runs only when the op is legal
	assign sts.div_busy = div_busy;
	assign sts.is_div   = (cmd_q == CMD_OPER) && (op_q == OP_DIV || op_q == OP_MOD)
		&& (err_q == ERR_NONE) && (cnt_q >= CNT_W'(2)) && (b_q != '0);
endmodule

// ===== rtl/pfe_ctrl.sv =====
//------------------------------------------------------------------------------
// pfe_ctrl
// Token sequencer: load, stack read, operand capture, execute, divide or finish.
//------------------------------------------------------------------------------
module pfe_ctrl import pfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_cmd,
	output logic       out_valid,
	input  logic       out_ready,
	input  pfe_sts_t   sts,
	output pfe_cmd_t   ctl
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_CAP  = 3'd2;
	localparam logic [2:0] S_EXEC = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0] state_q, state_nx;
	logic       out_valid_q;
	logic       take;

	// a token may only enter once the result register is free
	assign in_ready = (state_q == S_IDLE) && !(out_valid_q && !out_ready);
	assign take     = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		ctl      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				ctl.load = take;
				if (take) state_nx = S_READ;
			end
			S_READ: begin
				ctl.rd_top = 1'b1;
				state_nx   = S_CAP;
			end
			S_CAP: begin
				ctl.cap_ab = 1'b1;
				state_nx   = S_EXEC;
			end
			S_EXEC: begin
				if (sts.is_div) begin
					ctl.div_go = 1'b1;
					state_nx   = S_DIV;
				end else begin
					ctl.exec = 1'b1;
					state_nx = S_IDLE;
				end
			end
			S_DIV: begin
				// divider is already busy in the first cycle of this state
				if (!sts.div_busy) begin
					ctl.div_wb = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			S_FIN: begin
				ctl.fin  = 1'b1;
				state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	logic end_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			end_q         <= 1'b0;
		end else begin
			if (take) end_q <= (in_cmd == CMD_END);
			state_q <= (state_q == S_CAP && end_q) ? S_FIN : state_nx;
			if (state_q == S_FIN) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule
